FILE: src/tlpf_pkg.sv
// Shared constants, control word layout and microprogram of the page fault filler.
package tlpf_pkg;

    localparam int ENTRIES          = 1024;
    localparam int IDX_W            = 10;
    localparam int FRAME_W          = 20;
    localparam int VADDR_W          = 32;
    localparam int ENTRY_W          = 32;
    localparam int STAT_W           = 3;
    localparam int OP_W             = 2;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 20;
    localparam int SHARED_W         = 11;
    localparam int DEF_TABLE_FRAMES = 16;
    localparam int UPC_W            = 5;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_FAULT = 2'd1;

    localparam logic [STAT_W-1:0] STAT_FILLED    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NEW_TABLE = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_KERNEL = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NO_PROC   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_PROTECT   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NO_STORE  = 3'd5;
    localparam logic [STAT_W-1:0] STAT_INIT      = 3'd6;
    localparam logic [STAT_W-1:0] STAT_LOOKUP    = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_SHARED_PAGES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_BASE   = 8'd1;

    localparam logic [SHARED_W-1:0] SHARED_RESET = 11'd1024;
    localparam logic [FRAME_W-1:0]  BASE_RESET   = 20'd512;

    localparam logic [ENTRY_W-1:0] ENT_ABSENT    = 32'h0000_0002;
    localparam logic [11:0]        FLAGS_PRESENT = 12'h003;

    localparam logic [2:0] DIR_NONE     = 3'd0;
    localparam logic [2:0] DIR_READ     = 3'd1;
    localparam logic [2:0] DIR_WR_RST   = 3'd2;
    localparam logic [2:0] DIR_WR_INIT  = 3'd3;
    localparam logic [2:0] DIR_WR_FAULT = 3'd4;

    localparam logic [2:0] TBL_NONE    = 3'd0;
    localparam logic [2:0] TBL_READ    = 3'd1;
    localparam logic [2:0] TBL_WR_CLR  = 3'd2;
    localparam logic [2:0] TBL_WR_INIT = 3'd3;
    localparam logic [2:0] TBL_WR_PAGE = 3'd4;

    localparam logic [3:0] COND_NEVER        = 4'd0;
    localparam logic [3:0] COND_ALWAYS       = 4'd1;
    localparam logic [3:0] COND_NO_START     = 4'd2;
    localparam logic [3:0] COND_CNT_NOT_LAST = 4'd3;
    localparam logic [3:0] COND_OP_INIT      = 4'd4;
    localparam logic [3:0] COND_NOT_FAULT    = 4'd5;
    localparam logic [3:0] COND_PROT         = 4'd6;
    localparam logic [3:0] COND_KF_ZERO      = 4'd7;
    localparam logic [3:0] COND_KF_OUT       = 4'd8;
    localparam logic [3:0] COND_DENT_PRESENT = 4'd9;
    localparam logic [3:0] COND_DSLOT_OUT    = 4'd10;
    localparam logic [3:0] COND_PF_ZERO      = 4'd11;

    localparam logic [UPC_W-1:0] U_RST   = 5'd0;
    localparam logic [UPC_W-1:0] U_IDLE  = 5'd1;
    localparam logic [UPC_W-1:0] U_DISP  = 5'd2;
    localparam logic [UPC_W-1:0] U_FCHK  = 5'd3;
    localparam logic [UPC_W-1:0] U_FPROT = 5'd4;
    localparam logic [UPC_W-1:0] U_FDCAP = 5'd5;
    localparam logic [UPC_W-1:0] U_FBR   = 5'd6;
    localparam logic [UPC_W-1:0] U_NKZ   = 5'd7;
    localparam logic [UPC_W-1:0] U_NKOUT = 5'd8;
    localparam logic [UPC_W-1:0] U_NDIR  = 5'd9;
    localparam logic [UPC_W-1:0] U_NCLR  = 5'd10;
    localparam logic [UPC_W-1:0] U_NPFZ  = 5'd11;
    localparam logic [UPC_W-1:0] U_NPW   = 5'd12;
    localparam logic [UPC_W-1:0] U_PSLOT = 5'd13;
    localparam logic [UPC_W-1:0] U_PPFZ  = 5'd14;
    localparam logic [UPC_W-1:0] U_PPW   = 5'd15;
    localparam logic [UPC_W-1:0] U_IKZ   = 5'd16;
    localparam logic [UPC_W-1:0] U_IKOUT = 5'd17;
    localparam logic [UPC_W-1:0] U_ITAKE = 5'd18;
    localparam logic [UPC_W-1:0] U_ISWP  = 5'd19;
    localparam logic [UPC_W-1:0] U_LRD   = 5'd20;
    localparam logic [UPC_W-1:0] U_LCAP  = 5'd21;
    localparam logic [UPC_W-1:0] U_LTRD  = 5'd22;
    localparam logic [UPC_W-1:0] U_LTCAP = 5'd23;

    typedef struct packed {
        logic [UPC_W-1:0]  target;
        logic [3:0]        cond;
        logic [2:0]        dir_op;
        logic [2:0]        tbl_op;
        logic              cnt_clr;
        logic              cnt_inc;
        logic              stat_set;
        logic [STAT_W-1:0] stat;
        logic              cap_kslot;
        logic              cap_dslot;
        logic              take_k;
        logic              take_p;
        logic              cap_dent;
        logic              cap_tent;
    } ctl_t;

    typedef struct packed {
        logic cnt_last;
        logic op_init;
        logic op_fault;
        logic prot;
        logic kf_zero;
        logic kf_out;
        logic dent_present;
        logic dslot_out;
        logic pf_zero;
    } flg_t;

    function automatic ctl_t ucode(input logic [UPC_W-1:0] upc);
        ctl_t w;
        w = '0;
        case (upc)
            U_RST:
            begin
                w.dir_op  = DIR_WR_RST;
                w.cnt_inc = 1'b1;
                w.cond    = COND_CNT_NOT_LAST;
                w.target  = U_RST;
            end
            U_IDLE:
            begin
                w.cnt_clr = 1'b1;
                w.cond    = COND_NO_START;
                w.target  = U_IDLE;
            end
            U_DISP:
            begin
                w.cond   = COND_OP_INIT;
                w.target = U_IKZ;
            end
            U_FCHK:
            begin
                w.cond   = COND_NOT_FAULT;
                w.target = U_LRD;
            end
            U_FPROT:
            begin
                w.dir_op   = DIR_READ;
                w.stat_set = 1'b1;
                w.stat     = STAT_PROTECT;
                w.cond     = COND_PROT;
                w.target   = U_LRD;
            end
            U_FDCAP:
            begin
                w.cap_dent = 1'b1;
            end
            U_FBR:
            begin
                w.cond   = COND_DENT_PRESENT;
                w.target = U_PSLOT;
            end
            U_NKZ:
            begin
                w.stat_set = 1'b1;
                w.stat     = STAT_NO_KERNEL;
                w.cond     = COND_KF_ZERO;
                w.target   = U_LRD;
            end
            U_NKOUT:
            begin
                w.stat_set = 1'b1;
                w.stat     = STAT_NO_STORE;
                w.cond     = COND_KF_OUT;
                w.target   = U_LRD;
            end
            U_NDIR:
            begin
                w.dir_op    = DIR_WR_FAULT;
                w.cap_kslot = 1'b1;
                w.take_k    = 1'b1;
                w.stat_set  = 1'b1;
                w.stat      = STAT_NO_PROC;
            end
            U_NCLR:
            begin
                w.tbl_op  = TBL_WR_CLR;
                w.cnt_inc = 1'b1;
                w.cond    = COND_CNT_NOT_LAST;
                w.target  = U_NCLR;
            end
            U_NPFZ:
            begin
                w.cond   = COND_PF_ZERO;
                w.target = U_LRD;
            end
            U_NPW:
            begin
                w.tbl_op   = TBL_WR_PAGE;
                w.take_p   = 1'b1;
                w.stat_set = 1'b1;
                w.stat     = STAT_NEW_TABLE;
                w.cond     = COND_ALWAYS;
                w.target   = U_LRD;
            end
            U_PSLOT:
            begin
                w.cap_dslot = 1'b1;
                w.stat_set  = 1'b1;
                w.stat      = STAT_NO_STORE;
                w.cond      = COND_DSLOT_OUT;
                w.target    = U_LRD;
            end
            U_PPFZ:
            begin
                w.stat_set = 1'b1;
                w.stat     = STAT_NO_PROC;
                w.cond     = COND_PF_ZERO;
                w.target   = U_LRD;
            end
            U_PPW:
            begin
                w.tbl_op   = TBL_WR_PAGE;
                w.take_p   = 1'b1;
                w.stat_set = 1'b1;
                w.stat     = STAT_FILLED;
                w.cond     = COND_ALWAYS;
                w.target   = U_LRD;
            end
            U_IKZ:
            begin
                w.stat_set = 1'b1;
                w.stat     = STAT_NO_KERNEL;
                w.cond     = COND_KF_ZERO;
                w.target   = U_LRD;
            end
            U_IKOUT:
            begin
                w.stat_set = 1'b1;
                w.stat     = STAT_NO_STORE;
                w.cond     = COND_KF_OUT;
                w.target   = U_LRD;
            end
            U_ITAKE:
            begin
                w.cap_kslot = 1'b1;
                w.take_k    = 1'b1;
                w.stat_set  = 1'b1;
                w.stat      = STAT_INIT;
            end
            U_ISWP:
            begin
                w.dir_op  = DIR_WR_INIT;
                w.tbl_op  = TBL_WR_INIT;
                w.cnt_inc = 1'b1;
                w.cond    = COND_CNT_NOT_LAST;
                w.target  = U_ISWP;
            end
            U_LRD:
            begin
                w.dir_op = DIR_READ;
            end
            U_LCAP:
            begin
                w.cap_dent = 1'b1;
            end
            U_LTRD:
            begin
                w.tbl_op = TBL_READ;
            end
            U_LTCAP:
            begin
                w.cap_tent = 1'b1;
                w.cond     = COND_ALWAYS;
                w.target   = U_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: src/tlpf_ram.sv
// Generic single-port RAM with registered read data.
module tlpf_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: src/tlpf_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module tlpf_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tlpf_pkg::flg_t flg,
    output tlpf_pkg::ctl_t ctl,
    output logic          busy,
    output logic          accept
);
    import tlpf_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             jump;

    assign ctl    = ucode(upc_reg);
    assign busy   = (upc_reg != U_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        case (ctl.cond)
            COND_NEVER:        jump = 1'b0;
            COND_ALWAYS:       jump = 1'b1;
            COND_NO_START:     jump = !start;
            COND_CNT_NOT_LAST: jump = !flg.cnt_last;
            COND_OP_INIT:      jump = flg.op_init;
            COND_NOT_FAULT:    jump = !flg.op_fault;
            COND_PROT:         jump = flg.prot;
            COND_KF_ZERO:      jump = flg.kf_zero;
            COND_KF_OUT:       jump = flg.kf_out;
            COND_DENT_PRESENT: jump = flg.dent_present;
            COND_DSLOT_OUT:    jump = flg.dslot_out;
            COND_PF_ZERO:      jump = flg.pf_zero;
            default:           jump = 1'b0;
        endcase
        upc_next = jump ? ctl.target : upc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_RST;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

FILE: src/tlpf_dp.sv
// Datapath: latched request, configuration, directory and table store, result registers.
module tlpf_dp #(
    parameter int TABLE_FRAMES = tlpf_pkg::DEF_TABLE_FRAMES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlpf_pkg::ctl_t                    ctl,
    input  logic                              accept,
    output tlpf_pkg::flg_t                    flg,
    input  logic                              cfg_we,
    input  logic [tlpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlpf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [tlpf_pkg::OP_W-1:0]         op,
    input  logic [tlpf_pkg::VADDR_W-1:0]      virt_addr,
    input  logic                              protection_fault,
    input  logic [tlpf_pkg::FRAME_W-1:0]      kernel_frame,
    input  logic [tlpf_pkg::FRAME_W-1:0]      process_frame,
    output logic                              done,
    output logic [tlpf_pkg::STAT_W-1:0]       status,
    output logic                              kernel_frame_taken,
    output logic                              process_frame_taken,
    output logic [tlpf_pkg::ENTRY_W-1:0]      dir_entry,
    output logic [tlpf_pkg::ENTRY_W-1:0]      table_entry
);
    import tlpf_pkg::*;

    localparam int SLOT_W   = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int STORE_D  = TABLE_FRAMES * ENTRIES;
    localparam int STORE_AW = $clog2(STORE_D);

    logic [OP_W-1:0]     op_reg;
    logic [VADDR_W-1:0]  va_reg;
    logic                prot_reg;
    logic [FRAME_W-1:0]  kf_reg;
    logic [FRAME_W-1:0]  pf_reg;
    logic [SHARED_W-1:0] shared_reg;
    logic [FRAME_W-1:0]  base_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [STAT_W-1:0]   stat_reg;
    logic                kt_reg;
    logic                pt_reg;
    logic [ENTRY_W-1:0]  dent_reg;
    logic [ENTRY_W-1:0]  tent_reg;
    logic                done_reg;

    logic [IDX_W-1:0]    di;
    logic [IDX_W-1:0]    ti;
    logic [FRAME_W-1:0]  kdiff;
    logic [FRAME_W-1:0]  ddiff;
    logic                kin;
    logic                din;
    logic [SLOT_W-1:0]   kslot;
    logic [SLOT_W-1:0]   dslot;

    logic                dir_we;
    logic [IDX_W-1:0]    dir_addr;
    logic [ENTRY_W-1:0]  dir_wdata;
    logic [ENTRY_W-1:0]  dir_rdata;
    logic                tbl_we;
    logic [SLOT_W-1:0]   tbl_slot;
    logic [IDX_W-1:0]    tbl_idx;
    logic [SLOT_W+IDX_W-1:0] tbl_full;
    logic [STORE_AW-1:0] tbl_addr;
    logic [ENTRY_W-1:0]  tbl_wdata;
    logic [ENTRY_W-1:0]  tbl_rdata;

    assign di    = va_reg[31:22];
    assign ti    = va_reg[21:12];
    assign kdiff = kf_reg - base_reg;
    assign ddiff = dent_reg[31:12] - base_reg;
    assign kin   = (kf_reg >= base_reg) && (kdiff < FRAME_W'(TABLE_FRAMES));
    assign din   = (dent_reg[31:12] >= base_reg) && (ddiff < FRAME_W'(TABLE_FRAMES));
    assign kslot = kdiff[SLOT_W-1:0];
    assign dslot = ddiff[SLOT_W-1:0];

    assign flg.cnt_last     = (cnt_reg == IDX_W'(ENTRIES - 1));
    assign flg.op_init      = (op_reg == OP_INIT);
    assign flg.op_fault     = (op_reg == OP_FAULT);
    assign flg.prot         = prot_reg;
    assign flg.kf_zero      = (kf_reg == '0);
    assign flg.kf_out       = !kin;
    assign flg.dent_present = dent_reg[0];
    assign flg.dslot_out    = !din;
    assign flg.pf_zero      = (pf_reg == '0);

    always_comb
    begin
        dir_we    = 1'b0;
        dir_addr  = di;
        dir_wdata = ENT_ABSENT;
        case (ctl.dir_op)
            DIR_READ:
            begin
                dir_addr = di;
            end
            DIR_WR_RST:
            begin
                dir_we   = 1'b1;
                dir_addr = cnt_reg;
            end
            DIR_WR_INIT:
            begin
                dir_we   = 1'b1;
                dir_addr = cnt_reg;
                if (cnt_reg == '0)
                begin
                    dir_wdata = {kf_reg, FLAGS_PRESENT};
                end
            end
            DIR_WR_FAULT:
            begin
                dir_we    = 1'b1;
                dir_wdata = {kf_reg, FLAGS_PRESENT};
            end
            default:
            begin
                dir_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_slot  = slot_reg;
        tbl_idx   = ti;
        tbl_wdata = ENT_ABSENT;
        case (ctl.tbl_op)
            TBL_READ:
            begin
                tbl_slot = dslot;
            end
            TBL_WR_CLR:
            begin
                tbl_we  = 1'b1;
                tbl_idx = cnt_reg;
            end
            TBL_WR_INIT:
            begin
                tbl_we  = 1'b1;
                tbl_idx = cnt_reg;
                if ({1'b0, cnt_reg} < shared_reg)
                begin
                    tbl_wdata = {{(ENTRY_W - IDX_W - 12){1'b0}}, cnt_reg, FLAGS_PRESENT};
                end
            end
            TBL_WR_PAGE:
            begin
                tbl_we    = 1'b1;
                tbl_wdata = {pf_reg, FLAGS_PRESENT};
            end
            default:
            begin
                tbl_we = 1'b0;
            end
        endcase
        tbl_full = {tbl_slot, tbl_idx};
        tbl_addr = tbl_full[STORE_AW-1:0];
    end

    tlpf_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_dir (
        .clk   (clk),
        .we    (dir_we),
        .addr  (dir_addr),
        .wdata (dir_wdata),
        .rdata (dir_rdata)
    );

    tlpf_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (STORE_D),
        .ADDR_W (STORE_AW)
    ) u_store (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shared_reg <= SHARED_RESET;
            base_reg   <= BASE_RESET;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_SHARED_PAGES))
            begin
                shared_reg <= cfg_data[SHARED_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_TABLE_BASE))
            begin
                base_reg <= cfg_data[FRAME_W-1:0];
            end
            if (ctl.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (ctl.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            done_reg <= ctl.cap_tent;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            va_reg   <= virt_addr;
            prot_reg <= protection_fault;
            kf_reg   <= kernel_frame;
            pf_reg   <= process_frame;
            stat_reg <= STAT_LOOKUP;
            kt_reg   <= 1'b0;
            pt_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.stat_set)
            begin
                stat_reg <= ctl.stat;
            end
            if (ctl.take_k)
            begin
                kt_reg <= 1'b1;
            end
            if (ctl.take_p)
            begin
                pt_reg <= 1'b1;
            end
        end
        if (ctl.cap_kslot)
        begin
            slot_reg <= kslot;
        end
        else if (ctl.cap_dslot)
        begin
            slot_reg <= dslot;
        end
        if (ctl.cap_dent)
        begin
            dent_reg <= dir_rdata;
        end
        if (ctl.cap_tent)
        begin
            tent_reg <= (dent_reg[0] && din) ? tbl_rdata : '0;
        end
    end

    assign done                = done_reg;
    assign status              = stat_reg;
    assign kernel_frame_taken  = kt_reg;
    assign process_frame_taken = pt_reg;
    assign dir_entry           = dent_reg;
    assign table_entry         = tent_reg;

endmodule

FILE: src/two_level_page_fault_filler.sv
// Top level of the two-level page table fault filler.
// A request beat is taken at a rising edge with start high and busy low; op selects
// init, page fault or lookup, and the other fields give the address, the error bit and
// the offered kernel and process frames. Each request gives exactly one result beat:
// done is high for one cycle while status, the frame-taken flags, dir_entry and
// table_entry hold the result. The receiver cannot stall, so the result is simply
// presented for that cycle; a new request may be taken in that same cycle.
// Timing is set by the microcode sequencer, which runs one control word per cycle over
// single-port directory and table RAMs with registered reads; an init sweeps all 1024
// entries one per cycle. After reset the sequencer first writes every directory entry
// as not present, one entry per cycle, with busy high; configuration writes through the
// cfg channel are taken only while the block is idle (cfg_ready is low while busy).
module two_level_page_fault_filler #(
    parameter int TABLE_FRAMES = tlpf_pkg::DEF_TABLE_FRAMES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tlpf_pkg::OP_W-1:0]       op,
    input  logic [tlpf_pkg::VADDR_W-1:0]    virt_addr,
    input  logic                            protection_fault,
    input  logic [tlpf_pkg::FRAME_W-1:0]    kernel_frame,
    input  logic [tlpf_pkg::FRAME_W-1:0]    process_frame,
    output logic                            done,
    output logic [tlpf_pkg::STAT_W-1:0]     status,
    output logic                            kernel_frame_taken,
    output logic                            process_frame_taken,
    output logic [tlpf_pkg::ENTRY_W-1:0]    dir_entry,
    output logic [tlpf_pkg::ENTRY_W-1:0]    table_entry,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tlpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlpf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tlpf_pkg::*;

    ctl_t ctl;
    flg_t flg;
    logic accept;

    assign cfg_ready = !busy;

    tlpf_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .flg    (flg),
        .ctl    (ctl),
        .busy   (busy),
        .accept (accept)
    );

    tlpf_dp #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .ctl                 (ctl),
        .accept              (accept),
        .flg                 (flg),
        .cfg_we              (cfg_valid && cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .op                  (op),
        .virt_addr           (virt_addr),
        .protection_fault    (protection_fault),
        .kernel_frame        (kernel_frame),
        .process_frame       (process_frame),
        .done                (done),
        .status              (status),
        .kernel_frame_taken  (kernel_frame_taken),
        .process_frame_taken (process_frame_taken),
        .dir_entry           (dir_entry),
        .table_entry         (table_entry)
    );

endmodule

FILE: tb/sv/two_level_page_fault_filler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-level page fault filler with its own page walk predictor.
module two_level_page_fault_filler_tb;
    import tlpf_pkg::*;

    localparam int STORE_FRAMES = DEF_TABLE_FRAMES;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 24;

    localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP_ALT = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VADDR_W-1:0] vaddr;
        logic               prot;
        logic [FRAME_W-1:0] kframe;
        logic [FRAME_W-1:0] pframe;
    } fault_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               ktaken;
        logic               ptaken;
        logic [ENTRY_W-1:0] dent;
        logic [ENTRY_W-1:0] tent;
    } walk_result_t;

    logic                  clk              = 1'b0;
    logic                  rst_n            = 1'b0;
    logic                  start            = 1'b0;
    logic [OP_W-1:0]       op               = '0;
    logic [VADDR_W-1:0]    virt_addr        = '0;
    logic                  protection_fault = 1'b0;
    logic [FRAME_W-1:0]    kernel_frame     = '0;
    logic [FRAME_W-1:0]    process_frame    = '0;
    logic                  cfg_valid        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index        = '0;
    logic [CFG_DATA_W-1:0] cfg_data         = '0;
    logic                  busy;
    logic                  done;
    logic [STAT_W-1:0]     status;
    logic                  kernel_frame_taken;
    logic                  process_frame_taken;
    logic [ENTRY_W-1:0]    dir_entry;
    logic [ENTRY_W-1:0]    table_entry;
    logic                  cfg_ready;

    logic [ENTRY_W-1:0] shadow_dir [ENTRIES];
    logic [ENTRY_W-1:0] shadow_tables [STORE_FRAMES * ENTRIES];
    bit                 slot_filled [STORE_FRAMES];
    int unsigned        shared_cfg;
    int unsigned        base_cfg;
    logic [IDX_W-1:0]   hot_dirs [4];
    walk_result_t       pending_walks [$];
    int                 error_count = 0;
    int                 cycle_count = 0;

    two_level_page_fault_filler #(
        .TABLE_FRAMES(STORE_FRAMES)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .op                 (op),
        .virt_addr          (virt_addr),
        .protection_fault   (protection_fault),
        .kernel_frame       (kernel_frame),
        .process_frame      (process_frame),
        .done               (done),
        .status             (status),
        .kernel_frame_taken (kernel_frame_taken),
        .process_frame_taken(process_frame_taken),
        .dir_entry          (dir_entry),
        .table_entry        (table_entry),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic bit frame_in_store(int unsigned frame);
        return frame >= base_cfg && frame - base_cfg < STORE_FRAMES;
    endfunction

    function automatic walk_result_t apply_request(fault_req_t r);
        int unsigned  di;
        int unsigned  ti;
        int unsigned  slot;
        int unsigned  limit;
        int unsigned  i;
        walk_result_t res;
        di = r.vaddr[31:22];
        ti = r.vaddr[21:12];
        res = '0;
        res.status = STAT_LOOKUP;
        if (r.op == OP_INIT)
        begin
            if (r.kframe == '0)
            begin
                res.status = STAT_NO_KERNEL;
            end
            else if (!frame_in_store(r.kframe))
            begin
                res.status = STAT_NO_STORE;
            end
            else
            begin
                slot = r.kframe - base_cfg;
                limit = (shared_cfg > ENTRIES) ? ENTRIES : shared_cfg;
                for (i = 0; i < ENTRIES; i++)
                begin
                    shadow_tables[slot * ENTRIES + i] =
                        (i < limit) ? ((i << 12) | FLAGS_PRESENT) : ENT_ABSENT;
                end
                slot_filled[slot] = 1'b1;
                shadow_dir[0] = {r.kframe, FLAGS_PRESENT};
                for (i = 1; i < ENTRIES; i++)
                begin
                    shadow_dir[i] = ENT_ABSENT;
                end
                res.ktaken = 1'b1;
                res.status = STAT_INIT;
            end
        end
        else if (r.op == OP_FAULT)
        begin
            if (r.prot)
            begin
                res.status = STAT_PROTECT;
            end
            else if (!shadow_dir[di][0])
            begin
                if (r.kframe == '0)
                begin
                    res.status = STAT_NO_KERNEL;
                end
                else if (!frame_in_store(r.kframe))
                begin
                    res.status = STAT_NO_STORE;
                end
                else
                begin
                    slot = r.kframe - base_cfg;
                    shadow_dir[di] = {r.kframe, FLAGS_PRESENT};
                    for (i = 0; i < ENTRIES; i++)
                    begin
                        shadow_tables[slot * ENTRIES + i] = ENT_ABSENT;
                    end
                    slot_filled[slot] = 1'b1;
                    res.ktaken = 1'b1;
                    if (r.pframe == '0)
                    begin
                        res.status = STAT_NO_PROC;
                    end
                    else
                    begin
                        shadow_tables[slot * ENTRIES + ti] = {r.pframe, FLAGS_PRESENT};
                        res.ptaken = 1'b1;
                        res.status = STAT_NEW_TABLE;
                    end
                end
            end
            else if (!frame_in_store(shadow_dir[di][31:12]))
            begin
                res.status = STAT_NO_STORE;
            end
            else if (r.pframe == '0)
            begin
                res.status = STAT_NO_PROC;
            end
            else
            begin
                slot = shadow_dir[di][31:12] - base_cfg;
                shadow_tables[slot * ENTRIES + ti] = {r.pframe, FLAGS_PRESENT};
                res.ptaken = 1'b1;
                res.status = STAT_FILLED;
            end
        end
        res.dent = shadow_dir[di];
        if (res.dent[0] && frame_in_store(res.dent[31:12]))
        begin
            res.tent = shadow_tables[(res.dent[31:12] - base_cfg) * ENTRIES + ti];
        end
        return res;
    endfunction

    function automatic bit reads_unwritten(fault_req_t r);
        logic [ENTRY_W-1:0] dent;
        dent = shadow_dir[r.vaddr[31:22]];
        if (r.op == OP_INIT && r.kframe != '0 && frame_in_store(r.kframe))
        begin
            return 1'b0;
        end
        if (r.op == OP_FAULT && !r.prot && !dent[0])
        begin
            return 1'b0;
        end
        return dent[0] && frame_in_store(dent[31:12]) && !slot_filled[dent[31:12] - base_cfg];
    endfunction

    function automatic logic [FRAME_W-1:0] store_frame();
        int unsigned top;
        top = (base_cfg > 32'hFFFFF - (STORE_FRAMES - 1)) ? 32'hFFFFF - base_cfg
                                                          : STORE_FRAMES - 1;
        return FRAME_W'(base_cfg + $urandom_range(0, top));
    endfunction

    function automatic fault_req_t make_req(logic [OP_W-1:0] kind, logic [VADDR_W-1:0] va,
                                            logic prot, logic [FRAME_W-1:0] kf,
                                            logic [FRAME_W-1:0] pf);
        fault_req_t r;
        r = {kind, va, prot, kf, pf};
        return r;
    endfunction

    function automatic fault_req_t random_request();
        fault_req_t  r;
        int unsigned pick;
        r.vaddr = $urandom();
        if ($urandom_range(0, 9) < 7)
        begin
            r.vaddr[31:22] = ($urandom_range(0, 4) == 0) ? '0 : hot_dirs[$urandom_range(0, 3)];
        end
        pick = $urandom_range(0, 99);
        r.op = (pick < 4) ? OP_INIT : (pick < 66) ? OP_FAULT :
               (pick < 94) ? OP_LOOKUP : OP_LOOKUP_ALT;
        r.prot = ($urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 9);
        r.kframe = (pick == 0) ? '0 : (pick < 8) ? store_frame() : FRAME_W'($urandom());
        r.pframe = ($urandom_range(0, 9) == 0) ? '0 : FRAME_W'($urandom());
        return r;
    endfunction

    function automatic int unsigned next_burst();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    endfunction

    task automatic send_request(fault_req_t r);
        op <= r.op;
        virt_addr <= r.vaddr;
        protection_fault <= r.prot;
        kernel_frame <= r.kframe;
        process_frame <= r.pframe;
        start <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        pending_walks.push_back(apply_request(r));
    endtask

    task automatic pause_requests(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_walks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
    endtask

    task automatic program_regs(int unsigned shared, int unsigned base);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SHARED_PAGES;
        cfg_data <= CFG_DATA_W'(shared);
        do @(posedge clk); while (cfg_ready !== 1'b1);
        shared_cfg = shared & 32'h7FF;
        cfg_index <= REG_TABLE_BASE;
        cfg_data <= CFG_DATA_W'(base);
        do @(posedge clk); while (cfg_ready !== 1'b1);
        base_cfg = base & 32'hFFFFF;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_lookup_after_reset();
        send_request(make_req(OP_LOOKUP, 32'h0000_0000, 1'b0, '0, '0));
        send_request(make_req(OP_LOOKUP_ALT, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF, 20'hFFFFF));
        drain();
    endtask

    task automatic test_init_paths();
        send_request(make_req(OP_INIT, 32'h0000_0000, 1'b0, '0, 20'h00007));
        send_request(make_req(OP_INIT, 32'h0000_0000, 1'b0, FRAME_W'(base_cfg - 1), '0));
        send_request(make_req(OP_INIT, 32'h003F_F000, 1'b0,
                              FRAME_W'(base_cfg + STORE_FRAMES - 1), '0));
        send_request(make_req(OP_LOOKUP, 32'h0000_1ABC, 1'b0, '0, '0));
        drain();
    endtask

    task automatic test_fault_paths();
        send_request(make_req(OP_FAULT, 32'h0040_0000, 1'b1, FRAME_W'(base_cfg + 1), 20'h1));
        send_request(make_req(OP_FAULT, 32'h0040_0000, 1'b0, '0, 20'h5));
        send_request(make_req(OP_FAULT, 32'h0040_1000, 1'b0, 20'hFFFFF, 20'h5));
        send_request(make_req(OP_FAULT, 32'h0040_2000, 1'b0, FRAME_W'(base_cfg + 1), '0));
        send_request(make_req(OP_FAULT, 32'h0040_3000, 1'b0, FRAME_W'(base_cfg + 2), '0));
        send_request(make_req(OP_FAULT, 32'h007F_FFFF, 1'b0, '0, 20'hFFFFF));
        send_request(make_req(OP_FAULT, 32'h007F_F000, 1'b0, '0, 20'h00001));
        send_request(make_req(OP_FAULT, 32'hFFC0_0000, 1'b0, FRAME_W'(base_cfg + 2), 20'hABCDE));
        drain();
    endtask

    task automatic test_register_settings();
        program_regs(0, 512);
        send_request(make_req(OP_INIT, 32'h0000_0000, 1'b0, 20'd512, '0));
        drain();
        program_regs(2047, 512);
        send_request(make_req(OP_INIT, 32'h003F_F000, 1'b0, 20'd513, '0));
        send_request(make_req(OP_FAULT, 32'h0140_0000, 1'b0, 20'd515, 20'h12345));
        drain();
        program_regs(1, 520);
        send_request(make_req(OP_LOOKUP, 32'h0140_0000, 1'b0, '0, '0));
        send_request(make_req(OP_FAULT, 32'h0140_5000, 1'b0, 20'd520, 20'h00077));
        drain();
        program_regs(1, 1);
        send_request(make_req(OP_INIT, 32'h0000_0000, 1'b0, 20'd1, '0));
        send_request(make_req(OP_FAULT, 32'h01C0_0000, 1'b0, 20'd16, 20'hFFFFF));
        send_request(make_req(OP_FAULT, 32'h0200_0000, 1'b0, 20'd17, 20'h00001));
        drain();
        program_regs(1024, 20'hFFFFF);
        send_request(make_req(OP_INIT, 32'h0000_2000, 1'b0, 20'hFFFFF, '0));
        send_request(make_req(OP_FAULT, 32'h0240_0000, 1'b0, 20'hFFFFF, 20'h00003));
        drain();
    endtask

    task automatic test_random_traffic(int unsigned count, int unsigned shared,
                                       int unsigned base);
        fault_req_t  r;
        int unsigned burst;
        int unsigned n;
        program_regs(shared, base);
        foreach (hot_dirs[k])
        begin
            hot_dirs[k] = IDX_W'($urandom_range(0, ENTRIES - 1));
        end
        burst = next_burst();
        for (n = 0; n < count; n++)
        begin
            r = random_request();
            if (n == 0 || reads_unwritten(r))
            begin
                r.op = OP_INIT;
                r.kframe = store_frame();
            end
            send_request(r);
            if (burst == 0)
            begin
                pause_requests($urandom_range(1, 30));
                burst = next_burst();
            end
            else
            begin
                burst--;
            end
        end
        drain();
    endtask

    always @(posedge clk)
    begin : check_results
        walk_result_t want;
        walk_result_t got;
        if (rst_n && done)
        begin
            got = {status, kernel_frame_taken, process_frame_taken, dir_entry, table_entry};
            if (pending_walks.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("unexpected result beat: status %0d dir %h table %h",
                             got.status, got.dent, got.tent);
                end
            end
            else
            begin
                want = pending_walks.pop_front();
                if (got.status !== want.status || got.ktaken !== want.ktaken ||
                    got.ptaken !== want.ptaken || got.dent !== want.dent ||
                    got.tent !== want.tent)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected st %0d kt %b pt %b dir %h tbl %h",
                                 want.status, want.ktaken, want.ptaken, want.dent, want.tent);
                        $display("          actual   st %0d kt %b pt %b dir %h tbl %h",
                                 got.status, got.ktaken, got.ptaken, got.dent, got.tent);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        foreach (shadow_dir[i])
        begin
            shadow_dir[i] = ENT_ABSENT;
        end
        foreach (slot_filled[i])
        begin
            slot_filled[i] = 1'b0;
        end
        shared_cfg = SHARED_RESET;
        base_cfg = BASE_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_lookup_after_reset();
        test_init_paths();
        test_fault_paths();
        test_register_settings();
        test_random_traffic(140, $urandom_range(0, 2047), 512);
        test_random_traffic(140, 1024, $urandom_range(1, 20'hFFFF0));
        test_random_traffic(130, $urandom_range(0, 1024), 1);
        test_random_traffic(150, 2047, 20'hFFFFF);
        if (error_count == 0 && pending_walks.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/tlpf_pkg.sv
src/tlpf_ram.sv
src/tlpf_seq.sv
src/tlpf_dp.sv
src/two_level_page_fault_filler.sv
tb/sv/two_level_page_fault_filler_tb.sv
